@@ hw/rtl/v3a_pkg.sv @@
// ----------------------------------------------------------------------------
// v3a_pkg: shared types and helpers for the vector3 fixed-point ALU
// Opcodes, the sideband records that travel beside the datapath cells,
// and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package v3a_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int SQRT_STEPS    = 32;
   localparam int FRONT_STAGES  = 6;

   localparam logic signed [67:0] S32_MAX_W = 68'sd2147483647;
   localparam logic signed [67:0] S32_MIN_W = -68'sd2147483648;

   typedef enum logic [3:0] {
      OP_ADDS   = 4'd0,
      OP_SUBS   = 4'd1,
      OP_MULS   = 4'd2,
      OP_DIVS   = 4'd3,
      OP_ADD    = 4'd4,
      OP_SUB    = 4'd5,
      OP_NEG    = 4'd6,
      OP_DOT    = 4'd7,
      OP_CROSS  = 4'd8,
      OP_NCROSS = 4'd9,
      OP_NORM   = 4'd10,
      OP_SDOT   = 4'd11,
      OP_LEN    = 4'd12,
      OP_DIST2  = 4'd13,
      OP_DIST   = 4'd14,
      OP_EQ     = 4'd15
   } op_type;

   // sideband beside the square-root cells
   typedef struct packed {
      logic              vld;
      op_type            op;
      logic [2:0][31:0]  vec;
      logic [31:0]       scl;
      logic              eq;
      logic [2:0][32:0]  t;    // scaled components, signed
      logic [31:0]       s;    // scalar operand, signed
      logic              ovf;  // some component needed scaling
   } side_type;

   // one square-root step state
   typedef struct packed {
      logic [63:0] rad;
      logic [32:0] rem;
      logic [31:0] root;
   } sqrt_type;

   // sideband beside the divider cells
   typedef struct packed {
      logic              vld;
      op_type            op;
      logic [2:0][31:0]  vec;  // final vector, or fallback for divide ops
      logic [31:0]       scl;
      logic              eq;
      logic [2:0]        neg;
      logic              fb;   // zero divisor: take vec
   } dside_type;

   function automatic logic [31:0] sat32(input logic signed [67:0] v);
      if (v > S32_MAX_W) begin
         return 32'h7fff_ffff;
      end else if (v < S32_MIN_W) begin
         return 32'h8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

@@ hw/rtl/vector3_fixed_point_alu_top.sv @@
// Format: Q16.16 at the default FRAC_BITS; the pipe runs from start to rsp_valid.
// Throughput: one beat per cycle, every opcode; busy is never raised.
// The pipe runs through the front stages, the 32 square-root cells, the setup stage, the 32+FRAC_BITS divider cells.
// Reset: synchronous, active high; clears only the valid bits along the pipe.
// The receiver cannot stall: each result shows for one cycle with rsp_valid.
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu_top: three-component Q-format vector ALU
// Front stages (products, sums, scaling), a row of square-root cells, a
// setup stage, a row of divider cells, and the output register.
// ----------------------------------------------------------------------------
module vector3_fixed_point_alu_top #(
   parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_opcode,
   input  logic [31:0] req_a_x,
   input  logic [31:0] req_a_y,
   input  logic [31:0] req_a_z,
   input  logic [31:0] req_b_x,
   input  logic [31:0] req_b_y,
   input  logic [31:0] req_b_z,
   input  logic [31:0] req_scalar_in,
   output logic        rsp_valid,
   output logic [31:0] rsp_res_x,
   output logic [31:0] rsp_res_y,
   output logic [31:0] rsp_res_z,
   output logic [31:0] rsp_res_scalar,
   output logic        rsp_res_equal
);

   // numerator width: |component| <= 2^31, scaled by 2^FRAC_BITS
   localparam int NW  = 32 + FRAC_BITS;
   localparam int LAT = v3a_pkg::FRONT_STAGES + v3a_pkg::SQRT_STEPS + 2 + NW;
   localparam logic [NW-1:0] Q_ONE = NW'(1) << FRAC_BITS;

   // the pipe never holds off a beat
   assign busy = 1'b0;

   // ---------------- front stages ----------------
   v3a_pkg::side_type front_side;
   logic [63:0]       front_sum;

   v3a_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (start && !busy),
      .in_op    (v3a_pkg::op_type'(req_opcode)),
      .in_a     ({req_a_z, req_a_y, req_a_x}),
      .in_b     ({req_b_z, req_b_y, req_b_x}),
      .in_s     (req_scalar_in),
      .side_out (front_side),
      .sum_out  (front_sum)
   );

   // ---------------- square-root cell row ----------------
   // one root bit per cell; root of the sum of squares comes out of the last cell
   v3a_pkg::side_type side_w [v3a_pkg::SQRT_STEPS+1];
   v3a_pkg::sqrt_type st_w   [v3a_pkg::SQRT_STEPS+1];

   assign side_w[0]    = front_side;
   assign st_w[0].rad  = front_sum;
   assign st_w[0].rem  = '0;
   assign st_w[0].root = '0;

   for (genvar j = 0; j < v3a_pkg::SQRT_STEPS; j++) begin : g_sqrt
      v3a_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .side_in  (side_w[j]),
         .st_in    (st_w[j]),
         .side_out (side_w[j+1]),
         .st_out   (st_w[j+1])
      );
   end

   // ---------------- divider setup ----------------
   // length/distance finish here; divide ops load magnitudes and divisor.
   v3a_pkg::side_type  sq_side;
   logic [31:0]        len;
   v3a_pkg::dside_type d0_side_ff, d0_side_in;
   logic [2:0][NW-1:0] d0_num_ff, d0_num_in;
   logic [31:0]        d0_den_ff, d0_den_in;

   assign sq_side = side_w[v3a_pkg::SQRT_STEPS];
   assign len     = st_w[v3a_pkg::SQRT_STEPS].root;

   always_comb begin
      logic [31:0] len_sat;
      logic [32:0] tneg;
      logic [31:0] tmag;
      logic [31:0] smag;
      len_sat = len[31] ? 32'h7fff_ffff : len;
      smag    = sq_side.s[31] ? (32'd0 - sq_side.s) : sq_side.s;
      d0_side_in.vld = sq_side.vld;
      d0_side_in.op  = sq_side.op;
      d0_side_in.vec = sq_side.vec;
      d0_side_in.scl = sq_side.scl;
      d0_side_in.eq  = sq_side.eq;
      d0_side_in.fb  = 1'b0;
      d0_den_in      = len;
      for (int i = 0; i < 3; i++) begin
         tneg = 33'd0 - sq_side.t[i];
         tmag = sq_side.t[i][32] ? tneg[31:0] : sq_side.t[i][31:0];
         d0_num_in[i]     = {tmag, {FRAC_BITS{1'b0}}};
         d0_side_in.neg[i] = sq_side.t[i][32];
      end
      case (sq_side.op)
         v3a_pkg::OP_LEN: begin
            d0_side_in.scl = len_sat;
         end
         v3a_pkg::OP_DIST: begin
            // a component gap beyond 2^31 saturates the distance
            d0_side_in.scl = sq_side.ovf ? 32'h7fff_ffff : len_sat;
         end
         v3a_pkg::OP_DIVS: begin
            // divide by zero returns a unchanged
            d0_den_in     = smag;
            d0_side_in.fb = (sq_side.s == 32'd0);
            for (int i = 0; i < 3; i++) begin
               d0_side_in.vec[i] = sq_side.t[i][31:0];
               d0_side_in.neg[i] = sq_side.t[i][32] ^ sq_side.s[31];
            end
         end
         v3a_pkg::OP_NCROSS: begin
            // zero cross product gives the zero vector
            d0_side_in.fb  = (len == 32'd0);
            d0_side_in.vec = '0;
         end
         v3a_pkg::OP_NORM: begin
            // zero vector comes back unchanged
            d0_side_in.fb = (len == 32'd0);
            for (int i = 0; i < 3; i++) begin
               d0_side_in.vec[i] = sq_side.t[i][31:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d0_side_ff.vld <= 1'b0;
      end else begin
         d0_side_ff <= d0_side_in;
      end
      d0_num_ff <= d0_num_in;
      d0_den_ff <= d0_den_in;
   end

   // ---------------- divider cell row ----------------
   // one quotient bit per cell on all three lanes
   v3a_pkg::dside_type dside_w [NW+1];
   logic [2:0][NW-1:0] num_w   [NW+1];
   logic [2:0][31:0]   rem_w   [NW+1];
   logic [31:0]        den_w   [NW+1];

   assign dside_w[0] = d0_side_ff;
   assign num_w[0]   = d0_num_ff;
   assign rem_w[0]   = '0;
   assign den_w[0]   = d0_den_ff;

   for (genvar j = 0; j < NW; j++) begin : g_div
      v3a_div_cell #(.NW(NW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .side_in  (dside_w[j]),
         .num_in   (num_w[j]),
         .rem_in   (rem_w[j]),
         .den_in   (den_w[j]),
         .side_out (dside_w[j+1]),
         .num_out  (num_w[j+1]),
         .rem_out  (rem_w[j+1]),
         .den_out  (den_w[j+1])
      );
   end

   // ---------------- sign, saturation, output register ----------------
   v3a_pkg::dside_type dv;
   logic [2:0][NW-1:0] quo;
   logic               out_vld_ff;
   logic [2:0][31:0]   out_vec_ff, out_vec_in;
   logic [31:0]        out_scl_ff;
   logic               out_eq_ff;

   assign dv  = dside_w[NW];
   assign quo = num_w[NW];

   always_comb begin
      logic signed [67:0] qv;
      out_vec_in = dv.vec;
      for (int i = 0; i < 3; i++) begin
         qv = $signed(68'(quo[i]));
         if (dv.neg[i]) begin
            qv = -qv;
         end
         case (dv.op)
            v3a_pkg::OP_DIVS: begin
               out_vec_in[i] = dv.fb ? dv.vec[i] : v3a_pkg::sat32(qv);
            end
            v3a_pkg::OP_NCROSS, v3a_pkg::OP_NORM: begin
               out_vec_in[i] = dv.fb ? dv.vec[i] : qv[31:0];
            end
            default: begin
               out_vec_in[i] = dv.vec[i];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= dv.vld;
      end
      out_vec_ff <= out_vec_in;
      out_scl_ff <= dv.scl;
      out_eq_ff  <= dv.eq;
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_res_x      = out_vec_ff[0];
   assign rsp_res_y      = out_vec_ff[1];
   assign rsp_res_z      = out_vec_ff[2];
   assign rsp_res_scalar = out_scl_ff;
   assign rsp_res_equal  = out_eq_ff;

`ifndef SYNTH
   // every accepted beat shows up later as an rsp_valid beat
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("result beat missing at fixed latency");

   // unit-vector quotients never exceed one
   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      (dv.vld && !dv.fb && (dv.op == v3a_pkg::OP_NORM || dv.op == v3a_pkg::OP_NCROSS))
      |-> (quo[0] <= Q_ONE && quo[1] <= Q_ONE && quo[2] <= Q_ONE))
      else $error("normalized component above one");

   // an equality beat carries no vector or scalar
   a_equal_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_res_equal) |->
      (rsp_res_x == 32'd0 && rsp_res_y == 32'd0 && rsp_res_z == 32'd0 &&
       rsp_res_scalar == 32'd0))
      else $error("equality beat with nonzero payload");
`endif

endmodule

@@ hw/rtl/v3a_front.sv @@
// ----------------------------------------------------------------------------
// v3a_front: operand stages of the vector3 ALU
// Input register, product bank, product combine, scale search, scaling and
// squares, sum of squares. Feeds the square-root cell row.
// ----------------------------------------------------------------------------
module v3a_front #(
   parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_vld,
   input  v3a_pkg::op_type     in_op,
   input  logic [2:0][31:0]    in_a,
   input  logic [2:0][31:0]    in_b,
   input  logic [31:0]         in_s,
   output v3a_pkg::side_type   side_out,
   output logic [63:0]         sum_out
);

   // stage 0: input register
   logic                s0_vld_ff;
   v3a_pkg::op_type     s0_op_ff;
   logic [2:0][31:0]    s0_a_ff, s0_b_ff;
   logic [31:0]         s0_s_ff;
   logic [2:0][32:0]    s0_d_ff, s0_d_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s0_d_in[i] = {in_a[i][31], in_a[i]} - {in_b[i][31], in_b[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= in_vld;
      end
      s0_op_ff <= in_op;
      s0_a_ff  <= in_a;
      s0_b_ff  <= in_b;
      s0_s_ff  <= in_s;
      s0_d_ff  <= s0_d_in;
   end

   // stage 1: products and the simple elementwise ops
   logic                s1_vld_ff;
   v3a_pkg::op_type     s1_op_ff;
   logic [5:0][65:0]    s1_p_ff, s1_p_in;
   logic [2:0][31:0]    s1_v_ff, s1_v_in;
   logic                s1_eq_ff, s1_eq_in;
   logic [2:0][31:0]    s1_a_ff;
   logic [2:0][32:0]    s1_d_ff;
   logic [31:0]         s1_s_ff;
   logic [5:0][32:0]    ma, mb;

   always_comb begin
      logic signed [32:0] xa [3];
      logic signed [32:0] xb [3];
      logic signed [32:0] xs;
      logic signed [32:0] pa, pb;
      for (int i = 0; i < 3; i++) begin
         xa[i] = {s0_a_ff[i][31], s0_a_ff[i]};
         xb[i] = {s0_b_ff[i][31], s0_b_ff[i]};
      end
      xs = {s0_s_ff[31], s0_s_ff};
      ma = '0;
      mb = '0;
      case (s0_op_ff)
         v3a_pkg::OP_MULS: begin
            for (int i = 0; i < 3; i++) begin
               ma[i] = xa[i];
               mb[i] = xs;
            end
         end
         v3a_pkg::OP_DOT: begin
            for (int i = 0; i < 3; i++) begin
               ma[i] = xa[i];
               mb[i] = xb[i];
            end
         end
         v3a_pkg::OP_SDOT: begin
            for (int i = 0; i < 3; i++) begin
               ma[i] = xa[i];
               mb[i] = xa[i];
            end
         end
         v3a_pkg::OP_DIST2: begin
            for (int i = 0; i < 3; i++) begin
               ma[i] = s0_d_ff[i];
               mb[i] = s0_d_ff[i];
            end
         end
         v3a_pkg::OP_CROSS, v3a_pkg::OP_NCROSS: begin
            ma[0] = xa[1]; mb[0] = xb[2];
            ma[1] = xa[2]; mb[1] = xb[1];
            ma[2] = xa[2]; mb[2] = xb[0];
            ma[3] = xa[0]; mb[3] = xb[2];
            ma[4] = xa[0]; mb[4] = xb[1];
            ma[5] = xa[1]; mb[5] = xb[0];
         end
         default: begin
         end
      endcase
      for (int i = 0; i < 6; i++) begin
         pa = ma[i];
         pb = mb[i];
         s1_p_in[i] = $signed(66'(pa)) * $signed(66'(pb));
      end
   end

   always_comb begin
      logic signed [67:0] wa, wb, ws;
      s1_v_in = '0;
      ws = 68'($signed(s0_s_ff));
      for (int i = 0; i < 3; i++) begin
         wa = 68'($signed(s0_a_ff[i]));
         wb = 68'($signed(s0_b_ff[i]));
         case (s0_op_ff)
            v3a_pkg::OP_ADDS: s1_v_in[i] = v3a_pkg::sat32(wa + ws);
            v3a_pkg::OP_SUBS: s1_v_in[i] = v3a_pkg::sat32(wa - ws);
            v3a_pkg::OP_ADD:  s1_v_in[i] = v3a_pkg::sat32(wa + wb);
            v3a_pkg::OP_SUB:  s1_v_in[i] = v3a_pkg::sat32(wa - wb);
            v3a_pkg::OP_NEG:  s1_v_in[i] = v3a_pkg::sat32(-wa);
            default:          s1_v_in[i] = '0;
         endcase
      end
      s1_eq_in = (s0_op_ff == v3a_pkg::OP_EQ) && (s0_a_ff == s0_b_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s0_vld_ff;
      end
      s1_op_ff <= s0_op_ff;
      s1_p_ff  <= s1_p_in;
      s1_v_ff  <= s1_v_in;
      s1_eq_ff <= s1_eq_in;
      s1_a_ff  <= s0_a_ff;
      s1_d_ff  <= s0_d_ff;
      s1_s_ff  <= s0_s_ff;
   end

   // stage 2: fixed-point rescale, dot sums, cross components
   logic                s2_vld_ff;
   v3a_pkg::op_type     s2_op_ff;
   logic [2:0][31:0]    s2_v_ff, s2_v_in;
   logic [31:0]         s2_sc_ff, s2_sc_in;
   logic                s2_eq_ff;
   logic [2:0][63:0]    s2_c_ff, s2_c_in;
   logic [31:0]         s2_s_ff;

   always_comb begin
      logic signed [65:0] pi;
      logic signed [65:0] f [6];
      logic signed [65:0] h [6];
      logic signed [67:0] dsum;
      for (int i = 0; i < 6; i++) begin
         pi   = s1_p_ff[i];
         f[i] = pi >>> FRAC_BITS;
         h[i] = pi >>> 1;
      end
      dsum     = 68'(f[0]) + 68'(f[1]) + 68'(f[2]);
      s2_v_in  = s1_v_ff;
      s2_sc_in = '0;
      s2_c_in  = '0;
      case (s1_op_ff)
         v3a_pkg::OP_MULS: begin
            for (int i = 0; i < 3; i++) begin
               s2_v_in[i] = v3a_pkg::sat32(68'(f[i]));
            end
         end
         v3a_pkg::OP_DOT, v3a_pkg::OP_SDOT, v3a_pkg::OP_DIST2: begin
            s2_sc_in = v3a_pkg::sat32(dsum);
         end
         v3a_pkg::OP_CROSS: begin
            s2_v_in[0] = v3a_pkg::sat32(68'(f[0]) - 68'(f[1]));
            s2_v_in[1] = v3a_pkg::sat32(68'(f[2]) - 68'(f[3]));
            s2_v_in[2] = v3a_pkg::sat32(68'(f[4]) - 68'(f[5]));
         end
         v3a_pkg::OP_NCROSS: begin
            s2_c_in[0] = 64'(h[0] - h[1]);
            s2_c_in[1] = 64'(h[2] - h[3]);
            s2_c_in[2] = 64'(h[4] - h[5]);
         end
         v3a_pkg::OP_DIVS, v3a_pkg::OP_NORM, v3a_pkg::OP_LEN: begin
            for (int i = 0; i < 3; i++) begin
               s2_c_in[i] = 64'($signed(s1_a_ff[i]));
            end
         end
         v3a_pkg::OP_DIST: begin
            for (int i = 0; i < 3; i++) begin
               s2_c_in[i] = 64'($signed(s1_d_ff[i]));
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_op_ff <= s1_op_ff;
      s2_v_ff  <= s2_v_in;
      s2_sc_ff <= s2_sc_in;
      s2_eq_ff <= s1_eq_ff;
      s2_c_ff  <= s2_c_in;
      s2_s_ff  <= s1_s_ff;
   end

   // stage 3: least right shift that brings every magnitude to 2^31 or less
   logic                s3_vld_ff;
   v3a_pkg::op_type     s3_op_ff;
   logic [2:0][31:0]    s3_v_ff;
   logic [31:0]         s3_sc_ff;
   logic                s3_eq_ff;
   logic [2:0][63:0]    s3_c_ff;
   logic [31:0]         s3_s_ff;
   logic [5:0]          s3_k_ff, s3_k_in;

   always_comb begin
      logic [63:0] mag [3];
      logic [32:0] fits;
      for (int i = 0; i < 3; i++) begin
         mag[i] = s2_c_ff[i][63] ? (64'd0 - s2_c_ff[i]) : s2_c_ff[i];
      end
      for (int kk = 0; kk <= 32; kk++) begin
         fits[kk] = ((mag[0] >> kk) <= 64'h8000_0000) &&
                    ((mag[1] >> kk) <= 64'h8000_0000) &&
                    ((mag[2] >> kk) <= 64'h8000_0000);
      end
      s3_k_in = 6'd32;
      for (int kk = 32; kk >= 0; kk--) begin
         if (fits[kk]) begin
            s3_k_in = 6'(kk);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
      s3_op_ff <= s2_op_ff;
      s3_v_ff  <= s2_v_ff;
      s3_sc_ff <= s2_sc_ff;
      s3_eq_ff <= s2_eq_ff;
      s3_c_ff  <= s2_c_ff;
      s3_s_ff  <= s2_s_ff;
      s3_k_ff  <= s3_k_in;
   end

   // stage 4: floor shift, squares of magnitudes
   v3a_pkg::side_type   s4_side_ff, s4_side_in;
   logic [2:0][63:0]    s4_sq_ff, s4_sq_in;

   always_comb begin
      logic signed [63:0] cs, ts;
      logic [32:0]        tt;
      logic [32:0]        tneg;
      logic [31:0]        tm;
      s4_side_in.vld = s3_vld_ff;
      s4_side_in.op  = s3_op_ff;
      s4_side_in.vec = s3_v_ff;
      s4_side_in.scl = s3_sc_ff;
      s4_side_in.eq  = s3_eq_ff;
      s4_side_in.s   = s3_s_ff;
      s4_side_in.ovf = (s3_k_ff != 6'd0);
      for (int i = 0; i < 3; i++) begin
         cs   = s3_c_ff[i];
         ts   = cs >>> s3_k_ff;
         tt   = ts[32:0];
         tneg = 33'd0 - tt;
         tm   = tt[32] ? tneg[31:0] : tt[31:0];
         s4_side_in.t[i] = tt;
         s4_sq_in[i]     = 64'(tm) * 64'(tm);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_side_ff.vld <= 1'b0;
      end else begin
         s4_side_ff <= s4_side_in;
      end
      s4_sq_ff <= s4_sq_in;
   end

   // stage 5: sum of squares
   v3a_pkg::side_type   s5_side_ff;
   logic [63:0]         s5_sum_ff, s5_sum_in;

   assign s5_sum_in = s4_sq_ff[0] + s4_sq_ff[1] + s4_sq_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_side_ff.vld <= 1'b0;
      end else begin
         s5_side_ff <= s4_side_ff;
      end
      s5_sum_ff <= s5_sum_in;
   end

   assign side_out = s5_side_ff;
   assign sum_out  = s5_sum_ff;

endmodule

@@ hw/rtl/v3a_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// v3a_sqrt_cell: one digit of a floor integer square root
// Takes two radicand bits, settles one root bit, registers the result.
// ----------------------------------------------------------------------------
module v3a_sqrt_cell (
   input  logic                clock,
   input  logic                reset,
   input  v3a_pkg::side_type   side_in,
   input  v3a_pkg::sqrt_type   st_in,
   output v3a_pkg::side_type   side_out,
   output v3a_pkg::sqrt_type   st_out
);

   v3a_pkg::side_type side_ff;
   v3a_pkg::sqrt_type st_ff, st_step_in;

   always_comb begin
      logic [34:0] rem2, trial;
      logic        ge;
      rem2  = {st_in.rem[32:0], st_in.rad[63:62]};
      trial = {1'b0, st_in.root, 2'b01};
      ge    = (rem2 >= trial);
      st_step_in.rem  = ge ? 33'(rem2 - trial) : 33'(rem2);
      st_step_in.root = {st_in.root[30:0], ge};
      st_step_in.rad  = {st_in.rad[61:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.vld <= 1'b0;
      end else begin
         side_ff <= side_in;
      end
      st_ff <= st_step_in;
   end

   assign side_out = side_ff;
   assign st_out   = st_ff;

endmodule

@@ hw/rtl/v3a_div_cell.sv @@
// ----------------------------------------------------------------------------
// v3a_div_cell: one restoring-division step on three lanes
// Shared divisor; quotient bits shift into the low end of each numerator.
// ----------------------------------------------------------------------------
module v3a_div_cell #(
   parameter int NW = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  v3a_pkg::dside_type    side_in,
   input  logic [2:0][NW-1:0]    num_in,
   input  logic [2:0][31:0]      rem_in,
   input  logic [31:0]           den_in,
   output v3a_pkg::dside_type    side_out,
   output logic [2:0][NW-1:0]    num_out,
   output logic [2:0][31:0]      rem_out,
   output logic [31:0]           den_out
);

   v3a_pkg::dside_type side_ff;
   logic [2:0][NW-1:0] num_ff, num_step_in;
   logic [2:0][31:0]   rem_ff, rem_step_in;
   logic [31:0]        den_ff;

   always_comb begin
      logic [32:0] rem2;
      logic        ge;
      for (int i = 0; i < 3; i++) begin
         rem2 = {rem_in[i], num_in[i][NW-1]};
         ge   = (rem2 >= {1'b0, den_in});
         rem_step_in[i] = ge ? 32'(rem2 - {1'b0, den_in}) : rem2[31:0];
         num_step_in[i] = {num_in[i][NW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.vld <= 1'b0;
      end else begin
         side_ff <= side_in;
      end
      num_ff <= num_step_in;
      rem_ff <= rem_step_in;
      den_ff <= den_in;
   end

   assign side_out = side_ff;
   assign num_out  = num_ff;
   assign rem_out  = rem_ff;
   assign den_out  = den_ff;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for vector3_fixed_point_alu_top
// Drives opcode/vector/scalar beats through the start/busy handshake, predicts
// each result with a local Q16.16 model, and checks every rsp_valid beat in
// order. Directed extremes and special cases first, then a long random mix.
// ----------------------------------------------------------------------------
module testbench;

   localparam int FRAC       = 16;
   localparam int DRAIN_WAIT = 150;   // longer than the pipe latency
   localparam int IDLE_LIMIT = 4000;  // cycles with no beat moving either way
   localparam int RANDOM_CNT = 900;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] scl;
      logic        eq;
   } alu_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [3:0]  req_opcode = '0;
   logic [31:0] req_a_x = '0, req_a_y = '0, req_a_z = '0;
   logic [31:0] req_b_x = '0, req_b_y = '0, req_b_z = '0;
   logic [31:0] req_scalar_in = '0;
   logic        rsp_valid;
   logic [31:0] rsp_res_x, rsp_res_y, rsp_res_z, rsp_res_scalar;
   logic        rsp_res_equal;

   alu_result_type pending_results[$];
   int          error_count = 0;
   int          idle_cycles = 0;
   int          sent_count  = 0;
   int          checked_count = 0;

   always #1 clock = ~clock;

   vector3_fixed_point_alu_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_a_x        (req_a_x),
      .req_a_y        (req_a_y),
      .req_a_z        (req_a_z),
      .req_b_x        (req_b_x),
      .req_b_y        (req_b_y),
      .req_b_z        (req_b_z),
      .req_scalar_in  (req_scalar_in),
      .rsp_valid      (rsp_valid),
      .rsp_res_x      (rsp_res_x),
      .rsp_res_y      (rsp_res_y),
      .rsp_res_z      (rsp_res_z),
      .rsp_res_scalar (rsp_res_scalar),
      .rsp_res_equal  (rsp_res_equal)
   );

   // ------------------------------------------------------------------
   // Q-format arithmetic helpers
   // ------------------------------------------------------------------
   function automatic logic [31:0] clip32(input longint v);
      if (v > 64'sd2147483647) begin
         return 32'h7fff_ffff;
      end else if (v < -64'sd2147483648) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic longint unsigned magnitude(input longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   // product rounded toward minus infinity (arithmetic shift floors)
   function automatic longint qmul(input longint p, input longint q);
      return (p * q) >>> FRAC;
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned v);
      longint unsigned r;
      longint unsigned bq;
      r  = 0;
      bq = 64'h4000_0000_0000_0000;
      while (bq > v) bq = bq >> 2;
      while (bq != 0) begin
         if (v >= r + bq) begin
            v = v - (r + bq);
            r = (r >> 1) + bq;
         end else begin
            r = r >> 1;
         end
         bq = bq >> 2;
      end
      return r;
   endfunction

   // scale down until every magnitude fits 2^31, then divide by the length
   function automatic bit unit_vector(input longint c[3], output longint r[3]);
      longint unsigned m, sq, len;
      longint t[3];
      int k;
      m  = 0;
      sq = 0;
      k  = 0;
      r  = '{0, 0, 0};
      for (int i = 0; i < 3; i++) if (magnitude(c[i]) > m) m = magnitude(c[i]);
      while (k < 63 && (m >> k) > 64'h8000_0000) k++;
      for (int i = 0; i < 3; i++) begin
         t[i] = c[i] >>> k;
         sq += magnitude(t[i]) * magnitude(t[i]);
      end
      len = root_floor(sq);
      if (len == 0) return 1'b0;
      for (int i = 0; i < 3; i++) r[i] = (t[i] * 65536) / longint'(len);
      return 1'b1;
   endfunction

   function automatic alu_result_type vector_alu_predict(
      input logic [3:0] opc, input logic [31:0] aw[3], input logic [31:0] bw[3],
      input logic [31:0] sw);
      longint a[3], b[3], s, c[3], v[3], sc;
      longint unsigned acc, d;
      logic eq;
      alu_result_type res;
      v   = '{0, 0, 0};
      sc  = 0;
      eq  = 1'b0;
      acc = 0;
      s   = longint'($signed(sw));
      for (int i = 0; i < 3; i++) begin
         a[i] = longint'($signed(aw[i]));
         b[i] = longint'($signed(bw[i]));
      end
      case (v3a_pkg::op_type'(opc))
         v3a_pkg::OP_ADDS: for (int i = 0; i < 3; i++) v[i] = a[i] + s;
         v3a_pkg::OP_SUBS: for (int i = 0; i < 3; i++) v[i] = a[i] - s;
         v3a_pkg::OP_MULS: for (int i = 0; i < 3; i++) v[i] = qmul(a[i], s);
         v3a_pkg::OP_DIVS:
            for (int i = 0; i < 3; i++) v[i] = (s == 0) ? a[i] : (a[i] * 65536) / s;
         v3a_pkg::OP_ADD:  for (int i = 0; i < 3; i++) v[i] = a[i] + b[i];
         v3a_pkg::OP_SUB:  for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
         v3a_pkg::OP_NEG:  for (int i = 0; i < 3; i++) v[i] = -a[i];
         v3a_pkg::OP_DOT:  sc = qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]);
         v3a_pkg::OP_CROSS: begin
            v[0] = qmul(a[1], b[2]) - qmul(a[2], b[1]);
            v[1] = qmul(a[2], b[0]) - qmul(a[0], b[2]);
            v[2] = qmul(a[0], b[1]) - qmul(a[1], b[0]);
         end
         v3a_pkg::OP_NCROSS: begin
            c[0] = ((a[1] * b[2]) >>> 1) - ((a[2] * b[1]) >>> 1);
            c[1] = ((a[2] * b[0]) >>> 1) - ((a[0] * b[2]) >>> 1);
            c[2] = ((a[0] * b[1]) >>> 1) - ((a[1] * b[0]) >>> 1);
            if (!unit_vector(c, v)) v = '{0, 0, 0};
         end
         v3a_pkg::OP_NORM: if (!unit_vector(a, v)) v = a;
         v3a_pkg::OP_SDOT: sc = qmul(a[0], a[0]) + qmul(a[1], a[1]) + qmul(a[2], a[2]);
         v3a_pkg::OP_LEN: begin
            for (int i = 0; i < 3; i++) acc += magnitude(a[i]) * magnitude(a[i]);
            sc = longint'(root_floor(acc));
         end
         v3a_pkg::OP_DIST2: begin
            for (int i = 0; i < 3; i++) begin
               d = magnitude(a[i] - b[i]);
               acc += (d * d) >> FRAC;
            end
            sc = longint'(acc);
         end
         v3a_pkg::OP_DIST: begin
            sc = -1;
            for (int i = 0; i < 3; i++) begin
               d = magnitude(a[i] - b[i]);
               if (d > 64'h8000_0000) sc = 64'sd2147483647;
               acc += d * d;
            end
            if (sc < 0) sc = longint'(root_floor(acc));
         end
         default: eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
      endcase
      res.x   = clip32(v[0]);
      res.y   = clip32(v[1]);
      res.z   = clip32(v[2]);
      res.scl = clip32(sc);
      res.eq  = eq;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // beat driver and result checker
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH at %0t (result %0d): %s", $time, checked_count, what);
   endtask

   // waits 'gap' idle cycles, then holds start until a beat is taken
   task automatic send_op(input logic [3:0] opc, input logic [31:0] aw[3],
                          input logic [31:0] bw[3], input logic [31:0] sw,
                          input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_opcode    <= opc;
      req_a_x       <= aw[0];
      req_a_y       <= aw[1];
      req_a_z       <= aw[2];
      req_b_x       <= bw[0];
      req_b_y       <= bw[1];
      req_b_z       <= bw[2];
      req_scalar_in <= sw;
      do @(posedge clock); while (busy);
      pending_results.push_back(vector_alu_predict(opc, aw, bw, sw));
      sent_count++;
      idle_cycles = 0;
   endtask

   task automatic wait_all_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      alu_result_type e;
      if (!reset && rsp_valid) begin
         idle_cycles = 0;
         if (pending_results.size() == 0) begin
            report_mismatch("result beat with nothing outstanding");
         end else begin
            e = pending_results.pop_front();
            if (rsp_res_x !== e.x)
               report_mismatch($sformatf("res_x %h exp %h", rsp_res_x, e.x));
            if (rsp_res_y !== e.y)
               report_mismatch($sformatf("res_y %h exp %h", rsp_res_y, e.y));
            if (rsp_res_z !== e.z)
               report_mismatch($sformatf("res_z %h exp %h", rsp_res_z, e.z));
            if (rsp_res_scalar !== e.scl)
               report_mismatch($sformatf("res_scalar %h exp %h", rsp_res_scalar, e.scl));
            if (rsp_res_equal !== e.eq)
               report_mismatch($sformatf("res_equal %b exp %b", rsp_res_equal, e.eq));
         end
         checked_count++;
      end
   end

   // watchdog: nothing accepted on either side for too long
   always @(posedge clock) begin
      idle_cycles++;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("watchdog expired, %0d results outstanding", pending_results.size());
         $display("vector3_fixed_point_alu_top test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   // mix of full-range words, small Q16.16 values and corner words
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2, 3: return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
         4: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
         default: begin
            case ($urandom_range(0, 5))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0000_0000;
               3: return 32'hffff_ffff;
               4: return 32'h0001_0000;
               default: return 32'h0000_0001;
            endcase
         end
      endcase
   endfunction

   task automatic test_directed();
      logic [31:0] mx[3], mn[3], zr[3], ones[3], p[3], q[3];
      mx   = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
      mn   = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      zr   = '{0, 0, 0};
      ones = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
      p    = '{32'h0001_8000, 32'hfffe_0000, 32'h0003_4000};
      q    = '{32'hffff_c000, 32'h0002_0000, 32'h0000_8000};
      // every opcode on ordinary values
      for (int op = 0; op < 16; op++) send_op(op[3:0], p, q, 32'h0002_8000, 0);
      // saturation edges
      send_op(v3a_pkg::OP_ADDS, mx, zr, 32'h7fff_ffff, 1);
      send_op(v3a_pkg::OP_SUB,  mn, mx, 0, 0);
      send_op(v3a_pkg::OP_NEG,  mn, zr, 0, 2);      // negating the most negative value
      send_op(v3a_pkg::OP_MULS, mx, zr, 32'h8000_0000, 0);
      send_op(v3a_pkg::OP_DIVS, mn, zr, 32'hffff_ffff, 0);
      send_op(v3a_pkg::OP_DIVS, p, zr, 0, 0);       // zero divisor: a passes through
      send_op(v3a_pkg::OP_NORM, zr, zr, 0, 3);      // zero-length normalize
      send_op(v3a_pkg::OP_NCROSS, p, p, 0, 0);      // parallel: zero cross product
      send_op(v3a_pkg::OP_DIST, mn, mx, 0, 0);      // distance overflow
      send_op(v3a_pkg::OP_LEN, mn, zr, 0, 0);
      send_op(v3a_pkg::OP_DIST2, ones, mx, 0, 0);
      send_op(v3a_pkg::OP_EQ, ones, ones, 0, 0);
      send_op(v3a_pkg::OP_NCROSS, mx, '{32'h8000_0000, 32'h7fff_ffff, 32'h0}, 0, 0);
   endtask

   task automatic test_random(input int count);
      logic [31:0] a[3], b[3], s;
      logic [3:0]  opc;
      int gap;
      for (int n = 0; n < count; n++) begin
         opc = 4'($urandom_range(0, 15));
         for (int i = 0; i < 3; i++) begin
            a[i] = pick_word();
            b[i] = pick_word();
         end
         s = pick_word();
         if ($urandom_range(0, 9) == 0) b = a;                  // equal / parallel
         if (opc == v3a_pkg::OP_DIVS && $urandom_range(0, 9) == 0) s = 0;
         if (opc == v3a_pkg::OP_NORM && $urandom_range(0, 9) == 0) a = '{0, 0, 0};
         // stretches of back-to-back beats between bursts of gaps
         gap = ((n / 64) % 3 == 0) ? 0 : $urandom_range(0, 6);
         send_op(opc, a, b, s, gap);
         if (n == count / 2) wait_all_results();              // let the pipe empty
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_all_results();
      test_random(RANDOM_CNT);
      wait_all_results();
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("covered %0d beats: all 16 opcodes, saturation and zero-divisor cases,",
               sent_count);
      $display("zero-length normalize and random gaps; %0d results checked", checked_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("vector3_fixed_point_alu_top test passed");
      end else begin
         $display("vector3_fixed_point_alu_top test failed");
      end
      $finish;
   end

endmodule
